/* design/isst_pkg.sv */
// shared types, command codes and decode helper for the indexed stack store
package isst_pkg;

   // fixed field widths of the item and result ports
   localparam int IDX_WIDTH   = 8;
   localparam int FILL_WIDTH  = 9;
   localparam int CMD_WIDTH   = 3;

   // command codes as they arrive on the request port
   localparam logic [CMD_WIDTH-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_READ   = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE  = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_SWAP   = 3'd4;
   localparam logic [CMD_WIDTH-1:0] CMD_REMOVE = 3'd5;

   // decoded operation handed from front to back
   typedef enum logic [2:0] {
      OP_PUSH,
      OP_POP,
      OP_READ,
      OP_WRITE,
      OP_SWAP,
      OP_REMOVE,
      OP_NOP
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_TOP,
      BK_SWAP_A,
      BK_SWAP_B,
      BK_SWAP_C,
      BK_SHIFT
   } back_state_type;

   // control part of a queued item
   typedef struct packed {
      op_type                 op;
      logic [IDX_WIDTH-1:0]   index_a;
      logic [IDX_WIDTH-1:0]   index_b;
   } ctl_type;

   // map a raw command code to an operation
   function automatic op_type decode_command(input logic [CMD_WIDTH-1:0] cmd);
      op_type op;
      case (cmd)
         CMD_PUSH:   op = OP_PUSH;
         CMD_POP:    op = OP_POP;
         CMD_READ:   op = OP_READ;
         CMD_WRITE:  op = OP_WRITE;
         CMD_SWAP:   op = OP_SWAP;
         CMD_REMOVE: op = OP_REMOVE;
         default:    op = OP_NOP;
      endcase
      return op;
   endfunction

endpackage

/* design/isst_queue.sv */
// two-entry first-in first-out queue with push/full and pop/empty sides
module isst_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push, do_pop;

   // handshake qualifiers
   assign full    = (fill_ff == 2'd2);
   assign empty   = (fill_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* design/isst_front.sv */
// front end: takes request items, decodes the command and queues them
module isst_front #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [isst_pkg::CMD_WIDTH-1:0]    req_command,
   input  logic [isst_pkg::IDX_WIDTH-1:0]    req_index_a,
   input  logic [isst_pkg::IDX_WIDTH-1:0]    req_index_b,
   input  logic [DATA_WIDTH-1:0]             req_value_in,
   input  logic                              q_pop,
   output logic                              q_empty,
   output isst_pkg::ctl_type                 q_ctl,
   output logic [DATA_WIDTH-1:0]             q_value
);

   localparam int QW = $bits(isst_pkg::ctl_type) + DATA_WIDTH;

   isst_pkg::ctl_type ctl;
   logic [QW-1:0]     q_wdata, q_rdata;

   // classify the incoming command
   always_comb begin
      ctl.op      = isst_pkg::decode_command(req_command);
      ctl.index_a = req_index_a;
      ctl.index_b = req_index_b;
   end

   assign q_wdata = {ctl, req_value_in};

   isst_queue #(.WIDTH(QW)) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .wdata (q_wdata),
      .pop   (q_pop),
      .empty (q_empty),
      .rdata (q_rdata)
   );

   assign {q_ctl, q_value} = q_rdata;

endmodule

/* design/isst_back.sv */
// back end: element memory, fill count, top register and command sequencer
module isst_back #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  isst_pkg::ctl_type                 q_ctl,
   input  logic [DATA_WIDTH-1:0]             q_value,
   output logic                              q_pop,
   input  logic                              res_full,
   output logic                              res_valid,
   output logic [DATA_WIDTH-1:0]             res_read_value,
   output logic [isst_pkg::FILL_WIDTH-1:0]   res_fill_count,
   output logic [DATA_WIDTH-1:0]             res_top_value,
   output logic                              res_is_empty,
   output isst_pkg::status_type              res_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (CW > isst_pkg::IDX_WIDTH) ? CW : isst_pkg::IDX_WIDTH;

   isst_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [DATA_WIDTH-1:0]    top_ff, top_in;
   logic [AW-1:0]            ptr_ff, ptr_in;
   logic [AW-1:0]            idxb_ff, idxb_in;
   logic [DATA_WIDTH-1:0]    hold_ff, hold_in;
   logic [DATA_WIDTH-1:0]    rdata_ff;

   logic [DATA_WIDTH-1:0]    store_mem [DEPTH];
   logic                     mem_we, mem_re;
   logic [AW-1:0]            mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0]    mem_wdata;

   logic                     take;
   logic [IW-1:0]            ia_ext, ib_ext, cnt_ext;
   logic [AW-1:0]            ia_addr, ib_addr, ptr_next;
   logic [CW-1:0]            last_idx, below_last;
   logic                     a_ok, b_ok, a_last, is_full, is_zero, has_two, shift_done;
   logic [DATA_WIDTH-1:0]    read_in;
   isst_pkg::status_type     status_in;

   // index checks against the current fill count
   assign take       = (state_ff == isst_pkg::BK_IDLE) && !q_empty && !res_full;
   assign ia_ext     = IW'(q_ctl.index_a);
   assign ib_ext     = IW'(q_ctl.index_b);
   assign cnt_ext    = IW'(count_ff);
   assign ia_addr    = ia_ext[AW-1:0];
   assign ib_addr    = ib_ext[AW-1:0];
   assign a_ok       = ia_ext < cnt_ext;
   assign b_ok       = ib_ext < cnt_ext;
   assign last_idx   = count_ff - CW'(1);
   assign below_last = count_ff - CW'(2);
   assign a_last     = a_ok && (ia_ext == IW'(last_idx));
   assign is_full    = (count_ff == CW'(DEPTH));
   assign is_zero    = (count_ff == '0);
   assign has_two    = (count_ff > CW'(1));
   assign ptr_next   = ptr_ff + AW'(1);
   assign shift_done = ((CW'(ptr_ff) + CW'(1)) == last_idx);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         isst_pkg::BK_IDLE: begin
            if (take) begin
               case (q_ctl.op)
                  isst_pkg::OP_POP: begin
                     if (has_two) state_in = isst_pkg::BK_TOP;
                  end
                  isst_pkg::OP_READ: begin
                     if (a_ok) state_in = isst_pkg::BK_READ;
                  end
                  isst_pkg::OP_SWAP: begin
                     if (a_ok && b_ok) state_in = isst_pkg::BK_SWAP_A;
                  end
                  isst_pkg::OP_REMOVE: begin
                     if (a_last && has_two) state_in = isst_pkg::BK_TOP;
                     else if (a_ok && !a_last) state_in = isst_pkg::BK_SHIFT;
                  end
                  default: state_in = isst_pkg::BK_IDLE;
               endcase
            end
         end
         isst_pkg::BK_READ:   state_in = isst_pkg::BK_IDLE;
         isst_pkg::BK_TOP:    state_in = isst_pkg::BK_IDLE;
         isst_pkg::BK_SWAP_A: state_in = isst_pkg::BK_SWAP_B;
         isst_pkg::BK_SWAP_B: state_in = isst_pkg::BK_SWAP_C;
         isst_pkg::BK_SWAP_C: state_in = isst_pkg::BK_IDLE;
         isst_pkg::BK_SHIFT: begin
            if (shift_done) state_in = isst_pkg::BK_IDLE;
         end
         default: state_in = isst_pkg::BK_IDLE;
      endcase
   end

   // datapath, memory controls and result strobe
   always_comb begin
      count_in  = count_ff;
      top_in    = top_ff;
      ptr_in    = ptr_ff;
      idxb_in   = idxb_ff;
      hold_in   = hold_ff;
      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = rdata_ff;
      mem_re    = 1'b0;
      mem_raddr = ptr_ff;
      res_valid = 1'b0;
      read_in   = '0;
      status_in = isst_pkg::STAT_OK;
      case (state_ff)
         isst_pkg::BK_IDLE: begin
            if (take) begin
               case (q_ctl.op)
                  isst_pkg::OP_PUSH: begin
                     res_valid = 1'b1;
                     if (is_full) begin
                        status_in = isst_pkg::STAT_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = q_value;
                        count_in  = count_ff + CW'(1);
                        top_in    = q_value;
                     end
                  end
                  isst_pkg::OP_POP: begin
                     if (is_zero) begin
                        res_valid = 1'b1;
                        status_in = isst_pkg::STAT_EMPTY;
                     end else begin
                        count_in = last_idx;
                        if (has_two) begin
                           mem_re    = 1'b1;
                           mem_raddr = below_last[AW-1:0];
                        end else begin
                           top_in    = '0;
                           res_valid = 1'b1;
                        end
                     end
                  end
                  isst_pkg::OP_READ: begin
                     if (!a_ok) begin
                        res_valid = 1'b1;
                        status_in = isst_pkg::STAT_RANGE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = ia_addr;
                     end
                  end
                  isst_pkg::OP_WRITE: begin
                     res_valid = 1'b1;
                     if (!a_ok) begin
                        status_in = isst_pkg::STAT_RANGE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = ia_addr;
                        mem_wdata = q_value;
                        if (a_last) top_in = q_value;
                     end
                  end
                  isst_pkg::OP_SWAP: begin
                     if (!(a_ok && b_ok)) begin
                        res_valid = 1'b1;
                        status_in = isst_pkg::STAT_RANGE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = ia_addr;
                        ptr_in    = ia_addr;
                        idxb_in   = ib_addr;
                     end
                  end
                  isst_pkg::OP_REMOVE: begin
                     if (!a_ok) begin
                        res_valid = 1'b1;
                        status_in = isst_pkg::STAT_RANGE;
                     end else if (a_last) begin
                        // removing the top element works like a pop
                        count_in = last_idx;
                        if (has_two) begin
                           mem_re    = 1'b1;
                           mem_raddr = below_last[AW-1:0];
                        end else begin
                           top_in    = '0;
                           res_valid = 1'b1;
                        end
                     end else begin
                        // start the tail walk one place above the hole
                        mem_re    = 1'b1;
                        mem_raddr = ia_addr + AW'(1);
                        ptr_in    = ia_addr;
                     end
                  end
                  default: res_valid = 1'b1;
               endcase
            end
         end
         isst_pkg::BK_READ: begin
            res_valid = 1'b1;
            read_in   = rdata_ff;
         end
         isst_pkg::BK_TOP: begin
            top_in    = rdata_ff;
            res_valid = 1'b1;
         end
         isst_pkg::BK_SWAP_A: begin
            hold_in   = rdata_ff;
            mem_re    = 1'b1;
            mem_raddr = idxb_ff;
         end
         isst_pkg::BK_SWAP_B: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rdata_ff;
            if (CW'(ptr_ff) == last_idx) top_in = rdata_ff;
         end
         isst_pkg::BK_SWAP_C: begin
            mem_we    = 1'b1;
            mem_waddr = idxb_ff;
            mem_wdata = hold_ff;
            if (CW'(idxb_ff) == last_idx) top_in = hold_ff;
            res_valid = 1'b1;
         end
         isst_pkg::BK_SHIFT: begin
            // move one element down while fetching the next one
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rdata_ff;
            if (shift_done) begin
               count_in  = last_idx;
               res_valid = 1'b1;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ptr_next + AW'(1);
               ptr_in    = ptr_next;
            end
         end
         default: res_valid = 1'b0;
      endcase
   end

   assign q_pop          = take;
   assign res_read_value = read_in;
   assign res_fill_count = isst_pkg::FILL_WIDTH'(count_in);
   assign res_top_value  = top_in;
   assign res_is_empty   = (count_in == '0);
   assign res_status     = status_in;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isst_pkg::BK_IDLE;
         count_ff <= '0;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      idxb_ff <= idxb_in;
      hold_ff <= hold_in;
   end

   // element memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[mem_raddr];
      end
   end

   // fill count stays within capacity
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("fill count above capacity");

   // a result is only produced when the result queue has room
   assert property (@(posedge clock) disable iff (reset) res_valid |-> !res_full)
      else $error("result produced into full queue");

   // an empty store reports a zero top element
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == isst_pkg::BK_IDLE && count_ff == '0) |-> (top_ff == '0))
      else $error("top not cleared on empty store");

   // the tail walk only runs with at least two elements
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == isst_pkg::BK_SHIFT) |-> (count_ff > CW'(1)))
      else $error("tail walk with fewer than two elements");

   // simultaneous read and write never hit the same entry
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write collide on one entry");

endmodule

/* design/indexed_stack_store.sv */
// indexed stack store: array stack with push, pop, read, write, swap, remove-at
//
// Items come in on the req_ side as into a queue: an item is taken at a clock
// edge with req_push high and req_full low. A two-entry command queue sits in
// front of the execution unit, so req_full only rises when two items wait.
// Results leave through a two-entry result queue: the oldest result is on the
// rsp_ ports while rsp_empty is low and is taken with rsp_pop.
// Execution steps per item, set by the element memory with one write port and a
// registered read port: push, write, no-op and every error case finish in the
// step that takes the item; read adds a step for the registered read; pop and
// removal of the top add a step to load the new top, none when the last element
// goes; swap reads both entries, then writes them back exchanged; removal below
// the top moves each element above the index down one place, one per step.
// Single-step items run back to back at one per cycle while the result queue has
// room. Each result passes the command queue and the result queue on its way.
// Reset is synchronous and empties the store and both queues; the memory
// itself is not cleared. When the receiver stalls, results pile up in the
// result queue; once it is full the execution unit holds, then the command
// queue fills and req_full rises.
module indexed_stack_store #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [isst_pkg::CMD_WIDTH-1:0]    req_command,
   input  logic [isst_pkg::IDX_WIDTH-1:0]    req_index_a,
   input  logic [isst_pkg::IDX_WIDTH-1:0]    req_index_b,
   input  logic [DATA_WIDTH-1:0]             req_value_in,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [DATA_WIDTH-1:0]             rsp_read_value,
   output logic [isst_pkg::FILL_WIDTH-1:0]   rsp_fill_count,
   output logic [DATA_WIDTH-1:0]             rsp_top_value,
   output logic                              rsp_is_empty,
   output logic [1:0]                        rsp_status
);

   localparam int RW = DATA_WIDTH + isst_pkg::FILL_WIDTH + DATA_WIDTH + 1 + 2;

   isst_pkg::ctl_type                q_ctl;
   logic [DATA_WIDTH-1:0]            q_value;
   logic                             q_pop, q_empty;
   logic                             res_valid, res_full;
   logic [DATA_WIDTH-1:0]            res_read_value, res_top_value;
   logic [isst_pkg::FILL_WIDTH-1:0]  res_fill_count;
   logic                             res_is_empty;
   isst_pkg::status_type             res_status;
   logic [RW-1:0]                    res_wdata, res_rdata;

   // command intake
   isst_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_command  (req_command),
      .req_index_a  (req_index_a),
      .req_index_b  (req_index_b),
      .req_value_in (req_value_in),
      .q_pop        (q_pop),
      .q_empty      (q_empty),
      .q_ctl        (q_ctl),
      .q_value      (q_value)
   );

   // execution against the element memory
   isst_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_ctl          (q_ctl),
      .q_value        (q_value),
      .q_pop          (q_pop),
      .res_full       (res_full),
      .res_valid      (res_valid),
      .res_read_value (res_read_value),
      .res_fill_count (res_fill_count),
      .res_top_value  (res_top_value),
      .res_is_empty   (res_is_empty),
      .res_status     (res_status)
   );

   // result queue
   assign res_wdata = {res_read_value, res_fill_count, res_top_value, res_is_empty, res_status};

   isst_queue #(.WIDTH(RW)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_valid),
      .full  (res_full),
      .wdata (res_wdata),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (res_rdata)
   );

   assign {rsp_read_value, rsp_fill_count, rsp_top_value, rsp_is_empty, rsp_status} = res_rdata;

endmodule

/* tb/tb_indexed_stack_store.sv */
// self-checking testbench for the indexed stack store with a shadow stack predictor
module tb_indexed_stack_store;

   localparam int STORE_DEPTH = 256;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int ITEM_TOTAL  = 1825;
   localparam int SETTLE      = 16;

   // codes 6 and 7 have no meaning in the package, the block treats them as no-ops
   localparam logic [isst_pkg::CMD_WIDTH-1:0] CMD_UNUSED6 = 3'd6;
   localparam logic [isst_pkg::CMD_WIDTH-1:0] CMD_UNUSED7 = 3'd7;

   typedef enum {GROW, SHRINK, MIXED} drift_mode_type;

   typedef struct {
      logic [isst_pkg::CMD_WIDTH-1:0] command;
      logic [isst_pkg::IDX_WIDTH-1:0] index_a;
      logic [isst_pkg::IDX_WIDTH-1:0] index_b;
      logic [7:0]                     value_in;
   } stack_cmd_type;

   typedef struct {
      logic [7:0]                      read_value;
      logic [isst_pkg::FILL_WIDTH-1:0] fill_count;
      logic [7:0]                      top_value;
      logic                            is_empty;
      isst_pkg::status_type            status;
   } stack_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [isst_pkg::CMD_WIDTH-1:0] req_command = '0;
   logic [isst_pkg::IDX_WIDTH-1:0] req_index_a = '0;
   logic [isst_pkg::IDX_WIDTH-1:0] req_index_b = '0;
   logic [7:0] req_value_in = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [7:0] rsp_read_value;
   logic [isst_pkg::FILL_WIDTH-1:0] rsp_fill_count;
   logic [7:0] rsp_top_value;
   logic rsp_is_empty;
   logic [1:0] rsp_status;

   // items waiting to be sent and results still owed by the block
   stack_cmd_type pending_cmds[$];
   stack_rsp_type owed_results[$];

   // shadow copy of the stack contents
   logic [7:0] shadow_mem [0:STORE_DEPTH-1];
   logic [isst_pkg::FILL_WIDTH-1:0] shadow_count = '0;

   // fill level as seen by the stimulus generator, used to aim indices
   int plan_count = 0;
   int mismatches = 0;
   int cycle_count = 0;

   int burst_left = 1;
   int gap_left = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   int stall_span = 0;

   indexed_stack_store uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_command(req_command),
      .req_index_a(req_index_a),
      .req_index_b(req_index_b),
      .req_value_in(req_value_in),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_read_value(rsp_read_value),
      .rsp_fill_count(rsp_fill_count),
      .rsp_top_value(rsp_top_value),
      .rsp_is_empty(rsp_is_empty),
      .rsp_status(rsp_status)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // apply one command to the shadow stack and return the result it gives
   function automatic stack_rsp_type apply_to_shadow(stack_cmd_type c);
      stack_rsp_type r;
      logic [7:0] held;
      int k;
      r.read_value = '0;
      r.status = isst_pkg::STAT_OK;
      case (c.command)
         isst_pkg::CMD_PUSH: begin
            if (shadow_count >= STORE_DEPTH) begin
               r.status = isst_pkg::STAT_FULL;
            end else begin
               shadow_mem[shadow_count[7:0]] = c.value_in;
               shadow_count = shadow_count + 1'b1;
            end
         end
         isst_pkg::CMD_POP: begin
            if (shadow_count == 0) r.status = isst_pkg::STAT_EMPTY;
            else shadow_count = shadow_count - 1'b1;
         end
         isst_pkg::CMD_READ: begin
            if (c.index_a >= shadow_count) r.status = isst_pkg::STAT_RANGE;
            else r.read_value = shadow_mem[c.index_a];
         end
         isst_pkg::CMD_WRITE: begin
            if (c.index_a >= shadow_count) r.status = isst_pkg::STAT_RANGE;
            else shadow_mem[c.index_a] = c.value_in;
         end
         isst_pkg::CMD_SWAP: begin
            if (c.index_a >= shadow_count || c.index_b >= shadow_count) begin
               r.status = isst_pkg::STAT_RANGE;
            end else begin
               held = shadow_mem[c.index_a];
               shadow_mem[c.index_a] = shadow_mem[c.index_b];
               shadow_mem[c.index_b] = held;
            end
         end
         isst_pkg::CMD_REMOVE: begin
            if (c.index_a >= shadow_count) begin
               r.status = isst_pkg::STAT_RANGE;
            end else begin
               // close the gap by moving the tail down one place
               for (k = int'(c.index_a); k + 1 < int'(shadow_count); k++)
                  shadow_mem[k] = shadow_mem[k + 1];
               shadow_count = shadow_count - 1'b1;
            end
         end
         default: ;
      endcase
      r.fill_count = shadow_count;
      r.top_value = (shadow_count != 0) ? shadow_mem[8'(shadow_count - 1'b1)] : 8'h00;
      r.is_empty = (shadow_count == 0);
      return r;
   endfunction

   // queue one item and track the fill level it leads to
   function automatic void add_item(logic [isst_pkg::CMD_WIDTH-1:0] cmd, logic [7:0] a,
                                    logic [7:0] b, logic [7:0] v);
      stack_cmd_type c;
      c.command = cmd;
      c.index_a = a;
      c.index_b = b;
      c.value_in = v;
      pending_cmds.push_back(c);
      case (cmd)
         isst_pkg::CMD_PUSH: if (plan_count < STORE_DEPTH) plan_count++;
         isst_pkg::CMD_POP: if (plan_count > 0) plan_count--;
         isst_pkg::CMD_REMOVE: if (int'(a) < plan_count) plan_count--;
         default: ;
      endcase
   endfunction

   // mostly a valid index, sometimes any index at all
   function automatic logic [7:0] pick_index();
      if (plan_count != 0 && $urandom_range(0, 9) != 0)
         return 8'($urandom_range(0, plan_count - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   // one random item, with the command mix steering the fill level
   function automatic void add_random(drift_mode_type mode);
      int roll;
      logic [isst_pkg::CMD_WIDTH-1:0] cmd;
      logic [isst_pkg::CMD_WIDTH-1:0] spare;
      roll = $urandom_range(0, 99);
      spare = $urandom_range(0, 1) ? CMD_UNUSED6 : CMD_UNUSED7;
      case (mode)
         GROW: cmd = roll < 60 ? isst_pkg::CMD_PUSH : roll < 66 ? isst_pkg::CMD_POP :
                     roll < 76 ? isst_pkg::CMD_READ : roll < 86 ? isst_pkg::CMD_WRITE :
                     roll < 93 ? isst_pkg::CMD_SWAP : roll < 97 ? isst_pkg::CMD_REMOVE : spare;
         SHRINK: cmd = roll < 10 ? isst_pkg::CMD_PUSH : roll < 50 ? isst_pkg::CMD_POP :
                       roll < 75 ? isst_pkg::CMD_REMOVE : roll < 85 ? isst_pkg::CMD_READ :
                       roll < 92 ? isst_pkg::CMD_WRITE : roll < 98 ? isst_pkg::CMD_SWAP : spare;
         default: cmd = roll < 28 ? isst_pkg::CMD_PUSH : roll < 46 ? isst_pkg::CMD_POP :
                        roll < 61 ? isst_pkg::CMD_READ : roll < 75 ? isst_pkg::CMD_WRITE :
                        roll < 87 ? isst_pkg::CMD_SWAP : roll < 97 ? isst_pkg::CMD_REMOVE :
                        spare;
      endcase
      add_item(cmd, pick_index(), pick_index(), 8'($urandom_range(0, 255)));
   endfunction

   function automatic void check_field(string what, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // sender: bursts of items separated by random gaps
   always @(posedge clock) begin : sender
      logic send_now;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full)
            owed_results.push_back(apply_to_shadow(pending_cmds.pop_front()));
         send_now = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_cmds.size() > 0) begin
            send_now = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         req_push <= send_now;
         if (send_now) begin
            req_command <= pending_cmds[0].command;
            req_index_a <= pending_cmds[0].index_a;
            req_index_b <= pending_cmds[0].index_b;
            req_value_in <= pending_cmds[0].value_in;
         end
      end
   end

   // receiver: checks each result taken and stalls on a rotating pattern
   always @(posedge clock) begin : receiver
      stack_rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (owed_results.size() == 0) begin
               $display("%0t: result with none expected, actual count %0d status %0d",
                        $time, rsp_fill_count, rsp_status);
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               check_field("read_value", 9'(want.read_value), 9'(rsp_read_value));
               check_field("fill_count", want.fill_count, rsp_fill_count);
               check_field("top_value", 9'(want.top_value), 9'(rsp_top_value));
               check_field("is_empty", 9'(want.is_empty), 9'(rsp_is_empty));
               check_field("status", 9'(want.status), 9'(rsp_status));
            end
         end
         // new stall pattern every so often: none, random, heavy or light
         if (stall_span == 0) begin
            stall_span = $urandom_range(32, 300);
            case ($urandom_range(0, 3))
               0: stall_pattern = 16'hFFFF;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'h0101;
               default: stall_pattern = 16'($urandom | $urandom);
            endcase
            if (stall_pattern == 16'h0000) stall_pattern = 16'h8000;
         end else begin
            stall_span--;
         end
         stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         rsp_pop <= stall_pattern[0];
      end
   end

   initial begin
      // error cases on an empty stack
      add_item(isst_pkg::CMD_POP, 8'h00, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_READ, 8'h00, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_REMOVE, 8'h00, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_SWAP, 8'h00, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_WRITE, 8'h00, 8'h00, 8'hFF);
      // value extremes, then access at both ends and just past the top
      add_item(isst_pkg::CMD_PUSH, 8'h00, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_PUSH, 8'hFF, 8'hFF, 8'hFF);
      add_item(isst_pkg::CMD_PUSH, 8'h00, 8'h00, 8'hA5);
      add_item(isst_pkg::CMD_PUSH, 8'h00, 8'h00, 8'h5A);
      add_item(isst_pkg::CMD_READ, 8'h00, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_READ, 8'h03, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_READ, 8'h04, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_READ, 8'hFF, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_WRITE, 8'h01, 8'h00, 8'h3C);
      add_item(isst_pkg::CMD_SWAP, 8'h00, 8'h03, 8'h00);
      // swap of an index with itself
      add_item(isst_pkg::CMD_SWAP, 8'h02, 8'h02, 8'h00);
      add_item(isst_pkg::CMD_SWAP, 8'h01, 8'hFF, 8'h00);
      add_item(isst_pkg::CMD_SWAP, 8'hFF, 8'h01, 8'h00);
      add_item(CMD_UNUSED6, 8'h01, 8'h02, 8'h77);
      add_item(CMD_UNUSED7, 8'hFF, 8'hFF, 8'hFF);
      // remove from the middle, the top and the bottom
      add_item(isst_pkg::CMD_REMOVE, 8'h01, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_REMOVE, 8'h02, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_REMOVE, 8'h00, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_POP, 8'h00, 8'h00, 8'h00);
      add_item(isst_pkg::CMD_PUSH, 8'h00, 8'h00, 8'h81);

      // fill to capacity, then push into a full stack
      while (plan_count < STORE_DEPTH) add_random(GROW);
      repeat (3) add_item(isst_pkg::CMD_PUSH, pick_index(), pick_index(),
                          8'($urandom_range(0, 255)));
      while (pending_cmds.size() < ITEM_TOTAL / 2) begin
         drift_mode_type m;
         m = drift_mode_type'($urandom_range(0, 2));
         repeat ($urandom_range(40, 200)) add_random(m);
      end
      // drain to empty, then pop an empty stack
      while (plan_count > 0) add_random(SHRINK);
      repeat (2) add_item(isst_pkg::CMD_POP, pick_index(), pick_index(),
                          8'($urandom_range(0, 255)));
      while (pending_cmds.size() < ITEM_TOTAL) begin
         drift_mode_type m;
         m = drift_mode_type'($urandom_range(0, 2));
         repeat ($urandom_range(40, 200)) add_random(m);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (pending_cmds.size() != 0 || owed_results.size() != 0);
      repeat (SETTLE) @(negedge clock);
      if (mismatches == 0 && owed_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout with %0d items unsent and %0d results owed", $time,
               pending_cmds.size(), owed_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* indexed_stack_store.f */
design/isst_pkg.sv
design/isst_queue.sv
design/isst_front.sv
design/isst_back.sv
design/indexed_stack_store.sv
tb/tb_indexed_stack_store.sv
